>>> sv/rbp_pkg.sv
// ----------------------------------------------------------------------------
// rbp_pkg
// Shared types and constants of the reference counted block pool: command
// codes, sequencer states, request and response beats, register map.
// ----------------------------------------------------------------------------
package rbp_pkg;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned BLK_W  = 6;
  localparam int unsigned SIZE_W = 7;
  localparam int unsigned TOT_W  = 7;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [APB_ADDR_W-1:0] ADDR_POOL_SIZE = 3'h0;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 3'd0,
    CMD_ALLOC   = 3'd1,
    CMD_RELEASE = 3'd2,
    CMD_RETAIN  = 3'd3,
    CMD_TAKE    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COPY
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [BLK_W-1:0] block_index;
  } req_t;

  typedef struct packed {
    logic [BLK_W-1:0] result_block;
    logic             ok;
    logic             needs_copy;
    logic [TOT_W-1:0] used_count;
    logic [TOT_W-1:0] used_peak;
  } rsp_t;

endpackage

>>> sv/rbp_free_find.sv
// ----------------------------------------------------------------------------
// rbp_free_find
// Registered search for the lowest free block below the pool size in use.
// ----------------------------------------------------------------------------
module rbp_free_find import rbp_pkg::*; #(
  parameter int unsigned POOL_DEPTH = 64
) (
  input  logic                                            clk_i,
  input  logic [POOL_DEPTH-1:0]                           used_i,
  input  logic [SIZE_W-1:0]                               pool_size_i,
  output logic                                            found_o,
  output logic [((POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1)-1:0] idx_o
);

  localparam int unsigned IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;

  logic [POOL_DEPTH-1:0] cand;
  logic                  found_d, found_q;
  logic [IDX_W-1:0]      idx_d, idx_q;

  always_comb begin
    for (int i = 0; i < int'(POOL_DEPTH); i++) begin
      cand[i] = !used_i[i] && (32'(i) < 32'(pool_size_i));
    end
  end

  // lowest set candidate wins
  always_comb begin
    found_d = 1'b0;
    idx_d   = '0;
    for (int i = int'(POOL_DEPTH) - 1; i >= 0; i--) begin
      if (cand[i]) begin
        found_d = 1'b1;
        idx_d   = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    idx_q   <= idx_d;
  end

  assign found_o = found_q;
  assign idx_o   = idx_q;

endmodule

>>> sv/refcounted_block_pool_top.sv
// ----------------------------------------------------------------------------
// refcounted_block_pool_top
// Pool of buffer blocks with one reference count each, a used-block total
// and its high-water mark.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat (req_i) is taken at a clock edge with start high and busy
//   low. Its result beat is on result_o for one cycle with done_o high, the
//   cycle after the last busy cycle; the receiver cannot stall it.
//   Allocate, release, retain, clear and a take writable that keeps its
//   block first register the count read from the count memory's read port
//   while the free-block search is registered, then modify and write it
//   back in ST_EXEC. A take writable that gets a copy target also passes
//   through ST_COPY, since both the old and the new count are written
//   through the one write port. A new command may be started in the cycle
//   that shows the previous result. pool_size sits at APB byte address 0;
//   the user must see it is written only while idle; not enforced by the block.
//   Reset (and the clear command) empties the pool at once: a used bitmap
//   in flip-flops marks live entries, a count memory entry whose bit is
//   clear reads as zero, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module refcounted_block_pool_top import rbp_pkg::*; #(
  parameter int unsigned POOL_DEPTH = 64,
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  req_i,
  output logic                  done_o,
  output rsp_t                  result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned IDX_W   = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(POOL_DEPTH + 1);
  localparam int unsigned BEXT_W  = (IDX_W > BLK_W) ? IDX_W : BLK_W;
  localparam int unsigned TEXT_W  = (CNT_W > TOT_W) ? CNT_W : TOT_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // configuration
  logic [SIZE_W-1:0] pool_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_POOL_SIZE)) begin
      pool_size_q <= pwdata[SIZE_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_POOL_SIZE) ? APB_DATA_W'(pool_size_q) : '0;

  // control state
  state_e            state_q, state_d;
  logic [POOL_DEPTH-1:0] used_q, used_d;
  logic [CNT_W-1:0]  inuse_q, inuse_d;
  logic [CNT_W-1:0]  peak_q, peak_d;
  logic              done_q, done_d;

  // payload registers
  logic [CMD_W-1:0]  cmd_q;
  logic [BLK_W-1:0]  blk_q;
  logic [IDX_W-1:0]  addr_q;
  logic              in_range_q;
  rsp_t              rsp_q, rsp_d;

  // count memory
  logic [COUNT_BITS-1:0] mem_q [POOL_DEPTH];
  logic [COUNT_BITS-1:0] rdata_q;
  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [COUNT_BITS-1:0] wdata;

  logic              accept;
  logic [BEXT_W-1:0] blk_ext;
  logic [IDX_W-1:0]  rd_addr;

  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic [BEXT_W-1:0] free_ext;

  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0] cnt_dec;
  logic                  valid;
  logic [CNT_W-1:0]      inuse_inc;
  logic [TEXT_W-1:0]     inuse_ext, peak_ext;

  assign accept  = start && !busy;
  assign busy    = (state_q != ST_IDLE);
  assign blk_ext = BEXT_W'(req_i.block_index);
  assign rd_addr = blk_ext[IDX_W-1:0];

  rbp_free_find #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_free_find (
    .clk_i       (clk_i),
    .used_i      (used_q),
    .pool_size_i (pool_size_q),
    .found_o     (free_found),
    .idx_o       (free_idx)
  );

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (accept) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= req_i.command;
      blk_q      <= req_i.block_index;
      addr_q     <= rd_addr;
      in_range_q <= (32'(req_i.block_index) < 32'(POOL_DEPTH));
    end
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      used_q  <= '0;
      inuse_q <= '0;
      peak_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      inuse_q <= inuse_d;
      peak_q  <= peak_d;
      done_q  <= done_d;
    end
  end

  // an entry whose used bit is clear reads as a zero count
  assign valid     = in_range_q && used_q[addr_q];
  assign cnt       = valid ? rdata_q : '0;
  assign cnt_dec   = cnt - 1'b1;
  assign inuse_inc = inuse_q + 1'b1;
  assign free_ext  = BEXT_W'(free_idx);

  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    inuse_d   = inuse_q;
    peak_d    = peak_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    we        = 1'b0;
    waddr     = addr_q;
    wdata     = cnt;
    inuse_ext = TEXT_W'(inuse_q);
    peak_ext  = TEXT_W'(peak_q);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_d                = ST_IDLE;
        done_d                 = 1'b1;
        rsp_d.result_block     = '0;
        rsp_d.ok               = 1'b0;
        rsp_d.needs_copy       = 1'b0;
        case (cmd_e'(cmd_q))
          CMD_CLEAR: begin
            used_d   = '0;
            inuse_d  = '0;
            peak_d   = '0;
            rsp_d.ok = 1'b1;
          end
          CMD_ALLOC: begin
            if (free_found) begin
              used_d[free_idx]   = 1'b1;
              we                 = 1'b1;
              waddr              = free_idx;
              wdata              = COUNT_BITS'(1);
              inuse_d            = inuse_inc;
              if (inuse_inc > peak_q) peak_d = inuse_inc;
              rsp_d.result_block = free_ext[BLK_W-1:0];
              rsp_d.ok           = 1'b1;
            end
          end
          CMD_RELEASE: begin
            if (valid) begin
              we    = 1'b1;
              wdata = cnt_dec;
              if (cnt_dec == '0) begin
                used_d[addr_q] = 1'b0;
                if (inuse_q != '0) inuse_d = inuse_q - 1'b1;
              end
              rsp_d.result_block = blk_q;
              rsp_d.ok           = 1'b1;
            end
          end
          CMD_RETAIN: begin
            if (valid && (cnt != COUNT_MAX)) begin
              we                 = 1'b1;
              wdata              = cnt + 1'b1;
              rsp_d.result_block = blk_q;
              rsp_d.ok           = 1'b1;
            end
          end
          CMD_TAKE: begin
            if (valid) begin
              if (cnt == COUNT_BITS'(1)) begin
                rsp_d.result_block = blk_q;
                rsp_d.ok           = 1'b1;
              end else begin
                // shared: old count is at least two, so it stays in use
                we    = 1'b1;
                wdata = cnt_dec;
                if (free_found) begin
                  used_d[free_idx]   = 1'b1;
                  inuse_d            = inuse_inc;
                  if (inuse_inc > peak_q) peak_d = inuse_inc;
                  rsp_d.result_block = free_ext[BLK_W-1:0];
                  rsp_d.ok           = 1'b1;
                  rsp_d.needs_copy   = 1'b1;
                  state_d            = ST_COPY;
                  done_d             = 1'b0;
                end
              end
            end
          end
          default: begin
          end
        endcase
        inuse_ext        = TEXT_W'(inuse_d);
        peak_ext         = TEXT_W'(peak_d);
        rsp_d.used_count = inuse_ext[TOT_W-1:0];
        rsp_d.used_peak  = peak_ext[TOT_W-1:0];
      end

      ST_COPY: begin
        // second write: the copy target gets its single reference
        we      = 1'b1;
        waddr   = free_idx;
        wdata   = COUNT_BITS'(1);
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign done_o   = done_q;
  assign result_o = rsp_q;

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives command beats into refcounted_block_pool_top and checks each
// result beat against a cycle-free model of the pool: reference counts,
// used total and peak. The pool size register is reprogrammed between
// phases: disabled, tiny, full, oversized, and shrunk under live blocks.
// ----------------------------------------------------------------------------
module testbench;
  import rbp_pkg::*;

  localparam int unsigned DEPTH        = 64;
  localparam int unsigned CNT_W        = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned CALM_FIRST   = 250;
  localparam int unsigned CALM_LAST    = 450;

  localparam logic [CNT_W-1:0] CNT_MAX          = '1;
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_TAKE + 1;
  localparam logic [CMD_W-1:0] CMD_LAST_UNUSED  = '1;

  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  start   = 1'b0;
  logic                  busy;
  req_t                  req_i   = '0;
  logic                  done_o;
  rsp_t                  result_o;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // model of the pool
  logic [CNT_W-1:0]  hold_cnt [DEPTH] = '{default: '0};
  logic [TOT_W-1:0]  live_total = '0;
  logic [TOT_W-1:0]  live_peak  = '0;
  logic [SIZE_W-1:0] pool_cfg   = '0;

  req_t        pending_cmds [$];
  rsp_t        expected_rsps [$];
  int unsigned n_taken   = 0;
  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;

  refcounted_block_pool_top i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .req_i    (req_i),
    .done_o   (done_o),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int claim_block();
    int unsigned lim;
    int unsigned i;
    lim = (pool_cfg > DEPTH) ? DEPTH : pool_cfg;
    for (i = 0; i < lim; i++) begin
      if (hold_cnt[i] == '0) begin
        hold_cnt[i] = CNT_W'(1);
        live_total++;
        if (live_total > live_peak) live_peak = live_total;
        return i;
      end
    end
    return -1;
  endfunction

  function automatic void drop_hold(logic [BLK_W-1:0] b);
    hold_cnt[b]--;
    if (hold_cnt[b] == '0 && live_total != '0) live_total--;
  endfunction

  function automatic rsp_t pool_apply(req_t r);
    rsp_t             o;
    logic [BLK_W-1:0] b;
    bit               live;
    int               got;
    o    = '0;
    b    = r.block_index;
    live = hold_cnt[b] != '0;
    case (r.command)
      CMD_CLEAR: begin
        hold_cnt   = '{default: '0};
        live_total = '0;
        live_peak  = '0;
        o.ok       = 1'b1;
      end
      CMD_ALLOC: begin
        got = claim_block();
        if (got >= 0) begin
          o.result_block = BLK_W'(got);
          o.ok           = 1'b1;
        end
      end
      CMD_RELEASE: begin
        if (live) begin
          drop_hold(b);
          o.result_block = b;
          o.ok           = 1'b1;
        end
      end
      CMD_RETAIN: begin
        if (live && hold_cnt[b] != CNT_MAX) begin
          hold_cnt[b]++;
          o.result_block = b;
          o.ok           = 1'b1;
        end
      end
      CMD_TAKE: begin
        if (live && hold_cnt[b] == 1) begin
          o.result_block = b;
          o.ok           = 1'b1;
        end else if (live) begin
          // shared: copy target first, then the old block loses a holder
          got = claim_block();
          drop_hold(b);
          if (got >= 0) begin
            o.result_block = BLK_W'(got);
            o.ok           = 1'b1;
            o.needs_copy   = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    o.used_count = live_total;
    o.used_peak  = live_peak;
    return o;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("mismatch on %s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // driver: one command beat per accept, held while busy
  always @(posedge clk_i) begin : drive_cmds
    bit accepted;
    bit rest;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      accepted = start && !busy;
      if (accepted) begin
        expected_rsps.push_back(pool_apply(req_i));
        void'(pending_cmds.pop_front());
        n_taken++;
      end
      rest = (n_taken < CALM_FIRST || n_taken >= CALM_LAST) && ($urandom_range(99) < 6);
      if (start && !accepted) begin
        start <= 1'b1;
      end else if (pending_cmds.size() != 0 && !rest) begin
        start <= 1'b1;
        req_i <= pending_cmds[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: the receiver cannot stall, every done beat is taken
  always @(posedge clk_i) begin : watch_rsps
    rsp_t want;
    if (rst_ni && done_o) begin
      if (expected_rsps.size() == 0) begin
        $error("result beat with no command outstanding");
        err_cnt++;
      end else begin
        want = expected_rsps.pop_front();
        check_field("result_block", want.result_block, result_o.result_block);
        check_field("ok", want.ok, result_o.ok);
        check_field("needs_copy", want.needs_copy, result_o.needs_copy);
        check_field("used_count", want.used_count, result_o.used_count);
        check_field("used_peak", want.used_peak, result_o.used_peak);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_cmd(logic [CMD_W-1:0] cmd, logic [BLK_W-1:0] idx);
    req_t r;
    r.command     = cmd;
    r.block_index = idx;
    pending_cmds.push_back(r);
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || expected_rsps.size() != 0 || start)
      @(posedge clk_i);
  endtask

  task automatic apb_access(bit wr, logic [APB_ADDR_W-1:0] addr,
                            logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_pool(logic [SIZE_W-1:0] v);
    logic [APB_DATA_W-1:0] rd;
    wait_idle();
    apb_access(1'b1, ADDR_POOL_SIZE, APB_DATA_W'(v), rd);
    pool_cfg = v;
    apb_access(1'b0, ADDR_POOL_SIZE, '0, rd);
    check_field("pool_size", v, rd[SIZE_W-1:0]);
  endtask

  // live blocks sit low, so most indices fall in 0 to just above the pool size
  task automatic run_random(int unsigned n);
    int unsigned roll;
    int unsigned span;
    logic [BLK_W-1:0] idx;
    logic [CMD_W-1:0] cmd;
    span = (pool_cfg + 1 > DEPTH - 1) ? DEPTH - 1 : pool_cfg + 1;
    repeat (n) begin
      roll = $urandom_range(99);
      if ($urandom_range(9) == 0) idx = BLK_W'($urandom_range(DEPTH - 1));
      else                        idx = BLK_W'($urandom_range(span));
      if (roll < 35)      cmd = CMD_ALLOC;
      else if (roll < 60) cmd = CMD_RELEASE;
      else if (roll < 75) cmd = CMD_RETAIN;
      else if (roll < 92) cmd = CMD_TAKE;
      else if (roll < 95) cmd = CMD_CLEAR;
      else                cmd = CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
      push_cmd(cmd, idx);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // pool disabled out of reset
    push_cmd(CMD_ALLOC, 0);
    push_cmd(CMD_RELEASE, 0);
    push_cmd(CMD_RETAIN, 63);
    push_cmd(CMD_TAKE, 5);
    push_cmd(CMD_LAST_UNUSED, 63);
    push_cmd(CMD_CLEAR, 0);

    // two blocks: full pool, shared take with and without a free block
    set_pool(2);
    push_cmd(CMD_ALLOC, 0);
    push_cmd(CMD_ALLOC, 63);
    push_cmd(CMD_ALLOC, 0);
    push_cmd(CMD_RETAIN, 0);
    push_cmd(CMD_TAKE, 0);
    push_cmd(CMD_TAKE, 0);
    push_cmd(CMD_RETAIN, 1);
    push_cmd(CMD_RELEASE, 0);
    push_cmd(CMD_TAKE, 1);
    push_cmd(CMD_RELEASE, 1);
    push_cmd(CMD_RELEASE, 1);
    push_cmd(CMD_FIRST_UNUSED, 42);
    push_cmd(CMD_RETAIN, 63);
    push_cmd(CMD_CLEAR, 21);

    set_pool(64);
    run_random(75);

    // drive one count into saturation, then split it
    push_cmd(CMD_CLEAR, 0);
    push_cmd(CMD_ALLOC, 0);
    repeat (256) push_cmd(CMD_RETAIN, 0);
    push_cmd(CMD_TAKE, 0);
    push_cmd(CMD_RELEASE, 1);
    repeat (3) push_cmd(CMD_RELEASE, 0);

    set_pool(5);
    run_random(60);
    set_pool(127);
    run_random(60);
    set_pool(1);
    run_random(40);

    // shrink under live blocks: high blocks stay usable
    set_pool(64);
    push_cmd(CMD_CLEAR, 0);
    repeat (40) push_cmd(CMD_ALLOC, 0);
    set_pool(3);
    push_cmd(CMD_RELEASE, 30);
    push_cmd(CMD_RELEASE, 35);
    push_cmd(CMD_RETAIN, 39);
    push_cmd(CMD_TAKE, 20);
    push_cmd(CMD_TAKE, 39);
    push_cmd(CMD_ALLOC, 0);
    push_cmd(CMD_RELEASE, 1);
    push_cmd(CMD_ALLOC, 0);
    run_random(60);

    set_pool(SIZE_W'($urandom_range(4, 63)));
    run_random(60);
    set_pool(0);
    run_random(15);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
